// File: sv/htlm_pkg.sv
package htlm_pkg;

   // Fixed field widths of the request channel
   localparam int NODE_W   = 6;
   localparam int USER_IN_W = 16;
   localparam int PARENT_W = 7;

   // Operation codes
   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_LOCK    = 2'd1,
      OP_UNLOCK  = 2'd2,
      OP_UPGRADE = 2'd3
   } op_type;

   // Sequencer states
   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_CLEAR    = 7'b0000010,
      ST_LOOKUP   = 7'b0000100,
      ST_ANC      = 7'b0001000,
      ST_DSC_HEAD = 7'b0010000,
      ST_DSC_WALK = 7'b0100000,
      ST_FINISH   = 7'b1000000
   } state_type;

   // Result of one parent-pointer step
   typedef struct packed {
      logic in_range;
      logic hit;
   } walk_type;

   // Table write enables
   typedef struct packed {
      logic parent;
      logic lock;
      logic owner;
   } mem_we_type;

endpackage

// File: sv/htlm_ram.sv
module htlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/htlm_walk.sv
module htlm_walk #(
   parameter int NODES = 64,
   localparam int IW = $clog2(NODES)
) (
   input  logic [htlm_pkg::PARENT_W-1:0] parent,
   input  logic [IW-1:0]                 target,
   output htlm_pkg::walk_type            res,
   output logic [IW-1:0]                 idx
);

   logic [31:0] ext;

   // Negative or too-large parent values act as the root
   assign ext = {{(32 - htlm_pkg::PARENT_W + 1){1'b0}}, parent[htlm_pkg::PARENT_W-2:0]};
   assign idx = ext[IW-1:0];
   assign res.in_range = !parent[htlm_pkg::PARENT_W-1] && (ext < 32'(NODES));
   assign res.hit      = res.in_range && (idx == target);

endmodule

// File: sv/htlm_ctrl.sv
module htlm_ctrl #(
   parameter int NODES = 64,
   parameter int USER_WIDTH = 16,
   localparam int IW = $clog2(NODES),
   localparam int CW = $clog2(NODES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  htlm_pkg::op_type              req_op,
   input  logic [IW-1:0]                 req_idx,
   input  logic                          req_ok,
   input  logic [USER_WIDTH-1:0]         req_user,
   input  logic [htlm_pkg::PARENT_W-1:0] req_parent,
   input  logic                          lock_rd,
   input  logic [htlm_pkg::PARENT_W-1:0] parent_rd,
   input  logic [USER_WIDTH-1:0]         owner_rd,
   output logic [IW-1:0]                 rd_addr,
   output htlm_pkg::mem_we_type          we,
   output logic [IW-1:0]                 wr_addr,
   output logic                          lock_wd,
   output logic [htlm_pkg::PARENT_W-1:0] parent_wd,
   output logic [USER_WIDTH-1:0]         owner_wd,
   output logic                          rsp_valid,
   output logic                          rsp_granted
);

   htlm_pkg::state_type state_ff, state_in;
   htlm_pkg::op_type    op_ff, op_in;
   logic [IW-1:0]           node_ff, node_in;
   logic [USER_WIDTH-1:0]   user_ff, user_in;
   logic [IW-1:0]           d_ff, d_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    any_ff, any_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_granted_ff, rsp_granted_in;

   htlm_pkg::walk_type      walk;
   logic [IW-1:0]           walk_idx;
   logic                    d_last;
   logic                    cnt_full;
   logic                    clr;
   logic                    adv;
   logic                    scan;

   // Shared step unit: range check and target compare on one parent value
   htlm_walk #(.NODES(NODES)) u_walk (
      .parent (parent_rd),
      .target (node_ff),
      .res    (walk),
      .idx    (walk_idx)
   );

   assign d_last   = (d_ff == IW'(NODES - 1));
   assign cnt_full = (cnt_ff == CW'(NODES));

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      node_in        = node_ff;
      user_in        = user_ff;
      d_in           = d_ff;
      cnt_in         = cnt_ff;
      any_in         = any_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = rsp_granted_ff;
      rd_addr        = node_ff;
      we             = '0;
      wr_addr        = node_ff;
      lock_wd        = 1'b0;
      parent_wd      = req_parent;
      owner_wd       = user_ff;
      clr            = 1'b0;
      adv            = 1'b0;
      scan           = 1'b0;

      unique case (state_ff)
         htlm_pkg::ST_CLEAR: begin
            we.lock = 1'b1;
            wr_addr = d_ff;
            if (d_last) begin
               d_in     = '0;
               state_in = htlm_pkg::ST_IDLE;
            end else begin
               d_in = d_ff + IW'(1);
            end
         end
         htlm_pkg::ST_IDLE: begin
            if (start) begin
               op_in   = req_op;
               node_in = req_idx;
               user_in = req_user;
               rd_addr = req_idx;
               if (req_op == htlm_pkg::OP_LOAD) begin
                  we.parent      = req_ok;
                  wr_addr        = req_idx;
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b1;
               end else if (!req_ok) begin
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b0;
               end else begin
                  state_in = htlm_pkg::ST_LOOKUP;
               end
            end
         end
         htlm_pkg::ST_LOOKUP: begin
            rsp_granted_in = 1'b0;
            unique case (op_ff)
               htlm_pkg::OP_LOCK: begin
                  rsp_valid_in = 1'b1;
                  state_in     = htlm_pkg::ST_IDLE;
                  if (!lock_rd) begin
                     we.lock        = 1'b1;
                     we.owner       = 1'b1;
                     lock_wd        = 1'b1;
                     rsp_granted_in = 1'b1;
                  end
               end
               htlm_pkg::OP_UNLOCK: begin
                  rsp_valid_in = 1'b1;
                  state_in     = htlm_pkg::ST_IDLE;
                  if (lock_rd && (owner_rd == user_ff)) begin
                     we.lock        = 1'b1;
                     rsp_granted_in = 1'b1;
                  end
               end
               htlm_pkg::OP_UPGRADE: begin
                  if (lock_rd) begin
                     rsp_valid_in = 1'b1;
                     state_in     = htlm_pkg::ST_IDLE;
                  end else if (!walk.in_range) begin
                     scan = 1'b1;
                  end else begin
                     rd_addr  = walk_idx;
                     cnt_in   = CW'(1);
                     state_in = htlm_pkg::ST_ANC;
                  end
               end
               htlm_pkg::OP_LOAD: begin
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b1;
                  state_in       = htlm_pkg::ST_IDLE;
               end
            endcase
         end
         // Ancestor walk: data here is the lock and parent of the current ancestor
         htlm_pkg::ST_ANC: begin
            if (lock_rd) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b0;
               state_in       = htlm_pkg::ST_IDLE;
            end else if (cnt_full || !walk.in_range) begin
               scan = 1'b1;
            end else begin
               rd_addr = walk_idx;
               cnt_in  = cnt_ff + CW'(1);
            end
         end
         // Scan head: lock and parent of candidate d
         htlm_pkg::ST_DSC_HEAD: begin
            if (lock_rd && (d_ff != node_ff)) begin
               if (walk.hit) begin
                  clr = 1'b1;
                  adv = 1'b1;
               end else if (!walk.in_range) begin
                  adv = 1'b1;
               end else begin
                  rd_addr  = walk_idx;
                  cnt_in   = CW'(1);
                  state_in = htlm_pkg::ST_DSC_WALK;
               end
            end else begin
               adv = 1'b1;
            end
         end
         // Upward walk from a locked candidate
         htlm_pkg::ST_DSC_WALK: begin
            if (cnt_full) begin
               adv = 1'b1;
            end else if (walk.hit) begin
               clr = 1'b1;
               adv = 1'b1;
            end else if (!walk.in_range) begin
               adv = 1'b1;
            end else begin
               rd_addr = walk_idx;
               cnt_in  = cnt_ff + CW'(1);
            end
         end
         htlm_pkg::ST_FINISH: begin
            we.lock        = any_ff;
            we.owner       = any_ff;
            lock_wd        = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_granted_in = any_ff;
            state_in       = htlm_pkg::ST_IDLE;
         end
         default: begin
            state_in = htlm_pkg::ST_IDLE;
         end
      endcase

      // Start of the descendant scan at node zero
      if (scan) begin
         d_in     = '0;
         rd_addr  = '0;
         any_in   = 1'b0;
         state_in = htlm_pkg::ST_DSC_HEAD;
      end

      // Free a locked descendant
      if (clr) begin
         we.lock = 1'b1;
         wr_addr = d_ff;
         lock_wd = 1'b0;
         any_in  = 1'b1;
      end

      // Next candidate, or wrap up after the last one
      if (adv) begin
         if (d_last) begin
            state_in = htlm_pkg::ST_FINISH;
         end else begin
            d_in     = d_ff + IW'(1);
            rd_addr  = d_ff + IW'(1);
            state_in = htlm_pkg::ST_DSC_HEAD;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= htlm_pkg::ST_CLEAR;
         d_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         d_ff         <= d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      node_ff        <= node_in;
      user_ff        <= user_in;
      cnt_ff         <= cnt_in;
      any_ff         <= any_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   assign busy        = (state_ff != htlm_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;

endmodule

// File: sv/hierarchical_tree_lock_manager.sv
// Channel    Direction  Ports                                              Beat taken when
// request    in         req_operation req_node req_user req_parent_node   start && !busy
// response   out        rsp_granted                                        rsp_valid (one cycle)
//
// Load, and any operation on a node outside the tree, answers in the next cycle and the
// block takes a new request in that same cycle. Lock and unlock hold busy for a single
// table read. Upgrade steps through the single read port of the parent table, which serves
// every step of the ancestor walk and of each candidate's upward walk. After reset the
// block clears the lock flags, one per cycle, and stays busy until every flag is clear.
// The receiver cannot stall; a response is one beat on rsp_valid.
module hierarchical_tree_lock_manager #(
   parameter int NODES = 64,
   parameter int USER_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_operation,
   input  logic [htlm_pkg::NODE_W-1:0]          req_node,
   input  logic [htlm_pkg::USER_IN_W-1:0]       req_user,
   input  logic signed [htlm_pkg::PARENT_W-1:0] req_parent_node,
   output logic                                 rsp_valid,
   output logic                                 rsp_granted
);

   localparam int IW = $clog2(NODES);

   logic [31:0]                   node_ext;
   logic [31:0]                   user_ext;
   logic [IW-1:0]                 req_idx;
   logic                          req_ok;
   logic [USER_WIDTH-1:0]         req_user_m;

   logic [IW-1:0]                 rd_addr;
   logic [IW-1:0]                 wr_addr;
   htlm_pkg::mem_we_type          we;
   logic                          lock_wd;
   logic                          lock_rd;
   logic [htlm_pkg::PARENT_W-1:0] parent_wd;
   logic [htlm_pkg::PARENT_W-1:0] parent_rd;
   logic [USER_WIDTH-1:0]         owner_wd;
   logic [USER_WIDTH-1:0]         owner_rd;

   // Request decode: node range check, user masked to USER_WIDTH
   assign node_ext   = {{(32 - htlm_pkg::NODE_W){1'b0}}, req_node};
   assign user_ext   = {{(32 - htlm_pkg::USER_IN_W){1'b0}}, req_user};
   assign req_ok     = (node_ext < 32'(NODES));
   assign req_idx    = node_ext[IW-1:0];
   assign req_user_m = user_ext[USER_WIDTH-1:0];

   htlm_ctrl #(
      .NODES      (NODES),
      .USER_WIDTH (USER_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_op      (htlm_pkg::op_type'(req_operation)),
      .req_idx     (req_idx),
      .req_ok      (req_ok),
      .req_user    (req_user_m),
      .req_parent  (req_parent_node),
      .lock_rd     (lock_rd),
      .parent_rd   (parent_rd),
      .owner_rd    (owner_rd),
      .rd_addr     (rd_addr),
      .we          (we),
      .wr_addr     (wr_addr),
      .lock_wd     (lock_wd),
      .parent_wd   (parent_wd),
      .owner_wd    (owner_wd),
      .rsp_valid   (rsp_valid),
      .rsp_granted (rsp_granted)
   );

   // Parent table
   htlm_ram #(.WIDTH(htlm_pkg::PARENT_W), .DEPTH(NODES)) u_parent_ram (
      .clock (clock),
      .we    (we.parent),
      .waddr (wr_addr),
      .wdata (parent_wd),
      .raddr (rd_addr),
      .rdata (parent_rd)
   );

   // Lock flags
   htlm_ram #(.WIDTH(1), .DEPTH(NODES)) u_lock_ram (
      .clock (clock),
      .we    (we.lock),
      .waddr (wr_addr),
      .wdata (lock_wd),
      .raddr (rd_addr),
      .rdata (lock_rd)
   );

   // Owners
   htlm_ram #(.WIDTH(USER_WIDTH), .DEPTH(NODES)) u_owner_ram (
      .clock (clock),
      .we    (we.owner),
      .waddr (wr_addr),
      .wdata (owner_wd),
      .raddr (rd_addr),
      .rdata (owner_rd)
   );

   // An accepted request either answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor in progress");

   // A response is only given once the sequencer is back to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // An owner is only written together with setting the node's lock
   a_owner_with_lock: assert property (@(posedge clock) disable iff (reset)
      we.owner |-> (we.lock && lock_wd))
      else $error("owner written without lock");

endmodule
